>>> rtl/xmidi_to_midi_event_converter_macros.svh
// Assertion helpers shared by the checker.
`ifndef XMIDI_TO_MIDI_EVENT_CONVERTER_MACROS_SVH
`define XMIDI_TO_MIDI_EVENT_CONVERTER_MACROS_SVH

// same-cycle implication
`define XM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define XM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/xmtm_pkg.sv
package xmtm_pkg;

  typedef enum logic [3:0] {
    PH_HEADER, PH_IDLE, PH_CH_D1, PH_CH_D2, PH_ONE_D1, PH_NOTE_DUR,
    PH_META_TYPE, PH_META_LEN, PH_META_DATA
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PARSE, S_DRAIN_RD, S_DRAIN_CHK, S_EVENT, S_META_OUT,
    S_INS_RD, S_INS_CHK, S_END_CHK, S_DIV_START, S_DIV_WAIT, S_SUMMARY
  } state_t;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_META  = 2'd1,
    KIND_SUMM  = 2'd2
  } kind_t;

  localparam logic [7:0]  STATUS_MIN  = 8'h80;
  localparam logic [3:0]  HI_NOTE_ON  = 4'h9;
  localparam logic [3:0]  HI_PROG     = 4'hC;
  localparam logic [3:0]  HI_CHAN_PR  = 4'hD;
  localparam logic [3:0]  HI_SYSTEM   = 4'hF;
  localparam logic [7:0]  STATUS_META = 8'hFF;
  localparam logic [7:0]  META_TEMPO  = 8'h51;
  localparam logic [1:0]  HDR_LAST    = 2'd3;
  // x / 25000 == (x >> 3) / 3125; ceil(2^43 / 3125) is exact for x >> 3 below 2^31
  localparam logic [31:0] TD_RECIP    = 32'd2814749768;
  localparam int          TD_SHIFT    = 43;

endpackage

>>> rtl/xmtm_store.sv
// Pending note-off store: one write and one registered read per cycle.
module xmtm_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/xmtm_div.sv
// Time division: (3 * tempo) / 25000 by reciprocal multiply.
// The operand is registered on start, then multiplied and the quotient registered.
module xmtm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [33:0] dividend,
  output logic        busy,
  output logic [15:0] quotient
);
  import xmtm_pkg::*;

  logic [30:0] y_r, y_nxt;
  logic [15:0] q_r, q_nxt;
  logic        busy_r, busy_nxt;
  logic [62:0] prod;

  always_comb begin
    prod     = {32'd0, y_r} * {31'd0, TD_RECIP};
    y_nxt    = y_r;
    q_nxt    = q_r;
    busy_nxt = 1'b0;
    if (start) begin
      y_nxt    = dividend[33:3];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = prod[TD_SHIFT+15:TD_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    y_r <= y_nxt;
    q_r <= q_nxt;
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

>>> rtl/xmidi_to_midi_event_converter.sv
// XMIDI event chunk to MIDI event converter.
// Input stream: one chunk payload byte per transaction on in_tdata, in_tlast
// on the final byte of the chunk. The first 4 bytes of each chunk are skipped.
// Output stream: one result per transaction; out_tuser is the kind (0 MIDI
// event, 1 meta payload byte, 2 end summary), out_tlast marks the last result
// caused by one input byte.
// A byte that causes no result goes through S_PARSE and S_END_CHK. An event
// first drains due note-offs from the pending store, a read and a check each,
// then emits. Filing a note-off walks the store from its tail, a read and a
// check per entry moved. The end of chunk pops every pending note-off, then
// forms the time division by a reciprocal multiply before the summary.
// All work shares one store port pair and one sequencer; in_tready is high
// only while the sequencer is idle.
// Results sit in an output register; when the receiver stalls the sequencer
// waits at the next emit with all state held.
// Synchronous reset (rst_n low) empties the store, returns to header skip and
// drops any pending result. A summary empties the store and restarts the skip.
module xmidi_to_midi_event_converter #(
  parameter int PENDING_DEPTH = 32,
  parameter int TIME_BITS     = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] in_byte
  input  logic         in_tlast,   // end_of_chunk
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] delta, [39:32] status, [47:40] data_one, [55:48] data_two,
  // [63:56] payload_byte, [64] generated_off, [96:65] tempo,
  // [112:97] time_division, [113] overflow, [119:114] zero
  output logic [119:0] out_tdata,
  output logic [1:0]   out_tuser,  // [1:0] kind
  output logic         out_tlast   // last
);
  import xmtm_pkg::*;

  localparam int AW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW  = $clog2(PENDING_DEPTH + 1);
  localparam int EW  = TIME_BITS + 16;
  localparam int DXW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam logic [AW-1:0] LAST_IDX = AW'(PENDING_DEPTH - 1);

  // --- state ---
  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [1:0]           skip_r, skip_nxt;
  logic [TIME_BITS-1:0] cur_r, cur_nxt;
  logic [TIME_BITS-1:0] lastt_r, lastt_nxt;
  logic [7:0]           evst_r, evst_nxt;     // event_status
  logic [7:0]           evf_r, evf_nxt;       // event_first
  logic [TIME_BITS-1:0] dur_r, dur_nxt;
  logic [7:0]           mrem_r, mrem_nxt;
  logic [31:0]          tacc_r, tacc_nxt;
  logic [31:0]          ftempo_r, ftempo_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [7:0]           b_r, b_nxt;
  logic                 end_r, end_nxt;
  logic                 flush_r, flush_nxt;
  logic [7:0]           e_st_r, e_st_nxt, e_d1_r, e_d1_nxt, e_d2_r, e_d2_nxt;
  logic [AW-1:0]        iidx_r, iidx_nxt;
  logic [TIME_BITS-1:0] itime_r, itime_nxt;

  // --- output register ---
  logic         ov_r, ov_nxt;
  logic [1:0]   o_kind_r, o_kind_nxt;
  logic [31:0]  o_delta_r, o_delta_nxt;
  logic [7:0]   o_st_r, o_st_nxt, o_d1_r, o_d1_nxt, o_d2_r, o_d2_nxt;
  logic [7:0]   o_pay_r, o_pay_nxt;
  logic         o_gen_r, o_gen_nxt;
  logic [31:0]  o_tempo_r, o_tempo_nxt;
  logic [15:0]  o_td_r, o_td_nxt;
  logic         o_ovf_r, o_ovf_nxt;
  logic         o_last_r, o_last_nxt;

  // --- store and divider hookup ---
  logic          st_wr_en, st_rd_en;
  logic [AW-1:0] st_wr_addr, st_rd_addr;
  logic [EW-1:0] st_wr_data, st_rd_data;
  logic          div_start, div_busy;
  logic [15:0]   div_q;
  logic [33:0]   div_dvd;

  // --- helpers ---
  logic [TIME_BITS:0]   cur_add, due_add;
  logic [TIME_BITS-1:0] cur_plus_b, dur_new, due_time;
  logic [TIME_BITS-1:0] rd_time, em_time, em_diff;
  logic [DXW-1:0]       em_diff_x;
  logic [31:0]          em_delta;
  logic                 em_later;
  logic                 slot_free;
  logic [CW:0]          tail_sum;
  logic [AW-1:0]        tail_idx, iidx_prev;
  logic [3:0]           b_hi;

  assign rd_time    = st_rd_data[EW-1:16];
  assign slot_free  = !ov_r || out_tready;
  assign b_hi       = b_r[7:4];
  assign cur_add    = {1'b0, cur_r} + {{TIME_BITS-7{1'b0}}, b_r};
  assign cur_plus_b = cur_add[TIME_BITS] ? '1 : cur_add[TIME_BITS-1:0];
  assign dur_new    = (dur_r[TIME_BITS-1:TIME_BITS-7] != '0) ? '1 :
                      {dur_r[TIME_BITS-8:0], b_r[6:0]};
  assign due_add    = {1'b0, cur_r} + {1'b0, dur_new};
  assign due_time   = due_add[TIME_BITS] ? '1 : due_add[TIME_BITS-1:0];
  assign tail_sum   = (CW+1)'(head_r) + (CW+1)'(cnt_r);
  assign tail_idx   = (tail_sum >= (CW+1)'(PENDING_DEPTH)) ?
                      AW'(tail_sum - (CW+1)'(PENDING_DEPTH)) : AW'(tail_sum);
  assign iidx_prev  = (iidx_r == '0) ? LAST_IDX : iidx_r - AW'(1);
  assign div_dvd    = {2'b00, ftempo_r} + {1'b0, ftempo_r, 1'b0};

  // delta against the last emitted time, saturated to 32 bits
  assign em_time   = (state_r == S_DRAIN_CHK) ? rd_time : cur_r;
  assign em_later  = em_time > lastt_r;
  assign em_diff   = em_later ? em_time - lastt_r : '0;
  assign em_diff_x = DXW'(em_diff);
  assign em_delta  = (em_diff_x > DXW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : em_diff_x[31:0];

  always_comb begin
    state_nxt  = state_r;   phase_nxt  = phase_r;   skip_nxt   = skip_r;
    cur_nxt    = cur_r;     lastt_nxt  = lastt_r;   evst_nxt   = evst_r;
    evf_nxt    = evf_r;     dur_nxt    = dur_r;     mrem_nxt   = mrem_r;
    tacc_nxt   = tacc_r;    ftempo_nxt = ftempo_r;  head_nxt   = head_r;
    cnt_nxt    = cnt_r;     ovf_nxt    = ovf_r;     b_nxt      = b_r;
    end_nxt    = end_r;     flush_nxt  = flush_r;   e_st_nxt   = e_st_r;
    e_d1_nxt   = e_d1_r;    e_d2_nxt   = e_d2_r;    iidx_nxt   = iidx_r;
    itime_nxt  = itime_r;

    ov_nxt      = ov_r && !out_tready;
    o_kind_nxt  = o_kind_r;  o_delta_nxt = o_delta_r; o_st_nxt  = o_st_r;
    o_d1_nxt    = o_d1_r;    o_d2_nxt    = o_d2_r;    o_pay_nxt = o_pay_r;
    o_gen_nxt   = o_gen_r;   o_tempo_nxt = o_tempo_r; o_td_nxt  = o_td_r;
    o_ovf_nxt   = o_ovf_r;   o_last_nxt  = o_last_r;

    st_wr_en   = 1'b0;  st_wr_addr = iidx_r;  st_wr_data = st_rd_data;
    st_rd_en   = 1'b0;  st_rd_addr = head_r;
    div_start  = 1'b0;
    in_tready  = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          b_nxt     = in_tdata;
          end_nxt   = in_tlast;
          state_nxt = S_PARSE;
        end
      end

      S_PARSE: begin
        state_nxt = S_END_CHK;
        flush_nxt = 1'b0;
        case (phase_r)
          PH_HEADER: begin
            if (skip_r >= HDR_LAST) begin
              skip_nxt  = '0;
              phase_nxt = PH_IDLE;
            end else begin
              skip_nxt = skip_r + 2'd1;
            end
          end
          PH_CH_D1: begin
            evf_nxt   = b_r;
            phase_nxt = PH_CH_D2;
          end
          PH_CH_D2: begin
            e_st_nxt = evst_r; e_d1_nxt = evf_r; e_d2_nxt = b_r;
            state_nxt = S_DRAIN_RD;
            if (evst_r[7:4] == HI_NOTE_ON) begin
              dur_nxt   = '0;
              phase_nxt = PH_NOTE_DUR;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_ONE_D1: begin
            e_st_nxt = evst_r; e_d1_nxt = b_r; e_d2_nxt = '0;
            state_nxt = S_DRAIN_RD;
            phase_nxt = PH_IDLE;
          end
          PH_NOTE_DUR: begin
            dur_nxt = dur_new;
            if (!b_r[7]) begin
              phase_nxt = PH_IDLE;
              if (cnt_r == CW'(PENDING_DEPTH)) begin
                ovf_nxt = 1'b1;
              end else begin
                itime_nxt = due_time;
                iidx_nxt  = tail_idx;
                state_nxt = S_INS_RD;
              end
            end
          end
          PH_META_TYPE: begin
            evf_nxt   = b_r;
            phase_nxt = PH_META_LEN;
          end
          PH_META_LEN: begin
            mrem_nxt = b_r;
            tacc_nxt = '0;
            e_st_nxt = STATUS_META; e_d1_nxt = evf_r; e_d2_nxt = b_r;
            state_nxt = S_DRAIN_RD;
            phase_nxt = (b_r != '0) ? PH_META_DATA : PH_IDLE;
          end
          PH_META_DATA: begin
            state_nxt = S_META_OUT;
            if (evf_r == META_TEMPO) begin
              tacc_nxt = {tacc_r[23:0], b_r};
            end
            mrem_nxt = mrem_r - 8'd1;
            if (mrem_r == 8'd1) begin
              if (evf_r == META_TEMPO && ftempo_r == '0) begin
                ftempo_nxt = {tacc_r[23:0], b_r};
              end
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            if (b_r < STATUS_MIN) begin
              cur_nxt = cur_plus_b;
            end else begin
              evst_nxt = b_r;
              if (b_hi == HI_PROG || b_hi == HI_CHAN_PR) begin
                phase_nxt = PH_ONE_D1;
              end else if (b_hi != HI_SYSTEM) begin
                phase_nxt = PH_CH_D1;
              end else if (b_r == STATUS_META) begin
                phase_nxt = PH_META_TYPE;
              end else begin
                e_st_nxt = b_r; e_d1_nxt = '0; e_d2_nxt = '0;
                state_nxt = S_DRAIN_RD;
              end
            end
          end
        endcase
      end

      S_DRAIN_RD: begin
        if (cnt_r == '0) begin
          state_nxt = flush_r ? S_DIV_START : S_EVENT;
        end else begin
          st_rd_en   = 1'b1;
          st_rd_addr = head_r;
          state_nxt  = S_DRAIN_CHK;
        end
      end

      S_DRAIN_CHK: begin
        if (flush_r || rd_time <= cur_r) begin
          if (slot_free) begin
            ov_nxt      = 1'b1;
            o_kind_nxt  = KIND_EVENT;
            o_delta_nxt = em_delta;
            o_st_nxt    = st_rd_data[15:8];
            o_d1_nxt    = st_rd_data[7:0];
            o_d2_nxt    = '0;
            o_pay_nxt   = '0;
            o_gen_nxt   = 1'b1;
            o_tempo_nxt = '0;
            o_td_nxt    = '0;
            o_ovf_nxt   = ovf_r;
            o_last_nxt  = 1'b0;
            if (em_later) begin
              lastt_nxt = rd_time;
            end
            head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_DRAIN_RD;
          end
        end else begin
          state_nxt = S_EVENT;
        end
      end

      S_EVENT: begin
        if (slot_free) begin
          ov_nxt      = 1'b1;
          o_kind_nxt  = KIND_EVENT;
          o_delta_nxt = em_delta;
          o_st_nxt    = e_st_r;
          o_d1_nxt    = e_d1_r;
          o_d2_nxt    = e_d2_r;
          o_pay_nxt   = '0;
          o_gen_nxt   = 1'b0;
          o_tempo_nxt = '0;
          o_td_nxt    = '0;
          o_ovf_nxt   = ovf_r;
          o_last_nxt  = !end_r;
          if (em_later) begin
            lastt_nxt = cur_r;
          end
          state_nxt = S_END_CHK;
        end
      end

      S_META_OUT: begin
        if (slot_free) begin
          ov_nxt      = 1'b1;
          o_kind_nxt  = KIND_META;
          o_delta_nxt = '0;
          o_st_nxt    = STATUS_META;
          o_d1_nxt    = evf_r;
          o_d2_nxt    = '0;
          o_pay_nxt   = b_r;
          o_gen_nxt   = 1'b0;
          o_tempo_nxt = '0;
          o_td_nxt    = '0;
          o_ovf_nxt   = ovf_r;
          o_last_nxt  = !end_r;
          state_nxt   = S_END_CHK;
        end
      end

      // walk from the tail, moving later entries up one slot
      S_INS_RD: begin
        if (iidx_r == head_r) begin
          st_wr_en   = 1'b1;
          st_wr_data = {itime_r, evst_r, evf_r};
          cnt_nxt    = cnt_r + CW'(1);
          state_nxt  = S_END_CHK;
        end else begin
          st_rd_en   = 1'b1;
          st_rd_addr = iidx_prev;
          state_nxt  = S_INS_CHK;
        end
      end

      S_INS_CHK: begin
        st_wr_en = 1'b1;
        if (rd_time > itime_r) begin
          iidx_nxt  = iidx_prev;
          state_nxt = S_INS_RD;
        end else begin
          st_wr_data = {itime_r, evst_r, evf_r};
          cnt_nxt    = cnt_r + CW'(1);
          state_nxt  = S_END_CHK;
        end
      end

      S_END_CHK: begin
        if (end_r) begin
          flush_nxt = 1'b1;
          state_nxt = S_DRAIN_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_DIV_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (!div_busy) begin
          state_nxt = S_SUMMARY;
        end
      end

      S_SUMMARY: begin
        if (slot_free) begin
          ov_nxt      = 1'b1;
          o_kind_nxt  = KIND_SUMM;
          o_delta_nxt = '0;
          o_st_nxt    = '0;
          o_d1_nxt    = '0;
          o_d2_nxt    = '0;
          o_pay_nxt   = '0;
          o_gen_nxt   = 1'b0;
          o_tempo_nxt = ftempo_r;
          o_td_nxt    = div_q;
          o_ovf_nxt   = ovf_r;
          o_last_nxt  = 1'b1;
          // back to the state after reset
          phase_nxt  = PH_HEADER; skip_nxt = '0;   cur_nxt   = '0;
          lastt_nxt  = '0;        evst_nxt = '0;   evf_nxt   = '0;
          dur_nxt    = '0;        mrem_nxt = '0;   tacc_nxt  = '0;
          ftempo_nxt = '0;        head_nxt = '0;   cnt_nxt   = '0;
          ovf_nxt    = 1'b0;      flush_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;   phase_r  <= PH_HEADER; skip_r  <= '0;
      cur_r    <= '0;       lastt_r  <= '0;        evst_r  <= '0;
      evf_r    <= '0;       dur_r    <= '0;        mrem_r  <= '0;
      tacc_r   <= '0;       ftempo_r <= '0;        head_r  <= '0;
      cnt_r    <= '0;       ovf_r    <= 1'b0;      end_r   <= 1'b0;
      flush_r  <= 1'b0;     ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;  phase_r  <= phase_nxt;  skip_r  <= skip_nxt;
      cur_r    <= cur_nxt;    lastt_r  <= lastt_nxt;  evst_r  <= evst_nxt;
      evf_r    <= evf_nxt;    dur_r    <= dur_nxt;    mrem_r  <= mrem_nxt;
      tacc_r   <= tacc_nxt;   ftempo_r <= ftempo_nxt; head_r  <= head_nxt;
      cnt_r    <= cnt_nxt;    ovf_r    <= ovf_nxt;    end_r   <= end_nxt;
      flush_r  <= flush_nxt;  ov_r     <= ov_nxt;
    end
    b_r       <= b_nxt;     e_st_r    <= e_st_nxt;   e_d1_r  <= e_d1_nxt;
    e_d2_r    <= e_d2_nxt;  iidx_r    <= iidx_nxt;   itime_r <= itime_nxt;
    o_kind_r  <= o_kind_nxt;  o_delta_r <= o_delta_nxt; o_st_r  <= o_st_nxt;
    o_d1_r    <= o_d1_nxt;    o_d2_r    <= o_d2_nxt;    o_pay_r <= o_pay_nxt;
    o_gen_r   <= o_gen_nxt;   o_tempo_r <= o_tempo_nxt; o_td_r  <= o_td_nxt;
    o_ovf_r   <= o_ovf_nxt;   o_last_r  <= o_last_nxt;
  end

  xmtm_store #(
    .DEPTH (PENDING_DEPTH),
    .AW    (AW),
    .DW    (EW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  xmtm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign out_tvalid = ov_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {6'b0, o_ovf_r, o_td_r, o_tempo_r, o_gen_r, o_pay_r,
                       o_d2_r, o_d1_r, o_st_r, o_delta_r};

endmodule

>>> rtl/xmtm_checker.sv
`include "xmidi_to_midi_event_converter_macros.svh"

module xmtm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);
  import xmtm_pkg::*;

  `XM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `XM_ASSERT_NOW(a_summ_last, out_tvalid && out_tuser == KIND_SUMM, out_tlast, "summary not last")
  `XM_ASSERT_NOW(a_tempo_only_summ, out_tvalid && out_tuser != KIND_SUMM, out_tdata[112:65] == '0, "tempo outside summary")
  `XM_ASSERT_NOW(a_meta_status, out_tvalid && out_tuser == KIND_META, out_tdata[39:32] == STATUS_META && out_tdata[31:0] == '0, "bad meta byte result")

endmodule

bind xmidi_to_midi_event_converter xmtm_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import xmtm_pkg::*;

  localparam int  STORE_DEPTH = 32;
  localparam logic [63:0] TICK_MAX = 64'hFFFF_FFFF;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  TARGET_BYTES = 260;

  // one expected MIDI result
  typedef struct {
    kind_t       kind;
    logic [31:0] delta;
    logic [7:0]  status;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [7:0]  payload;
    logic        gen_off;
    logic [31:0] tempo;
    logic [15:0] tdiv;
    logic        ovf;
    logic        last;
  } midi_res_t;

  typedef struct {
    logic [7:0] b;
    logic       eoc;
  } chunk_byte_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // [7:0] in_byte
  logic         in_tlast;   // end_of_chunk
  logic         out_tvalid;
  logic         out_tready;
  // [31:0] delta, [39:32] status, [47:40] data_one, [55:48] data_two,
  // [63:56] payload_byte, [64] generated_off, [96:65] tempo,
  // [112:97] time_division, [113] overflow
  logic [119:0] out_tdata;
  logic [1:0]   out_tuser;  // [1:0] kind
  logic         out_tlast;

  xmidi_to_midi_event_converter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  chunk_byte_t chunk_bytes[$];
  midi_res_t   midi_expected[$];
  int          bytes_sent;
  int          results_seen;
  int          errors;
  int          cycles;
  int          hold_at;     // sender pauses here until all results are back
  int          quiet_from;  // no idling past this byte
  int          chunks_made;

  // ---------------------------------------------------------------------
  // Converter predictor state
  // ---------------------------------------------------------------------
  phase_t      p_phase;
  logic [1:0]  p_skip;
  logic [63:0] p_now;
  logic [31:0] p_seq;
  logic [63:0] p_last_out;
  logic [7:0]  p_status;
  logic [7:0]  p_first;
  logic [63:0] p_dur;
  logic [7:0]  p_meta_left;
  logic [31:0] p_tempo_acc;
  logic [31:0] p_tempo;
  logic [63:0] off_due[STORE_DEPTH];
  logic [15:0] off_note[STORE_DEPTH];
  int          off_count;
  logic        p_ovf;
  int          step_results;

  function automatic logic [63:0] tick_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > TICK_MAX) ? TICK_MAX : s;
  endfunction

  task automatic clear_converter();
    p_phase = PH_HEADER;
    p_skip = '0;
    p_now = '0;
    p_seq = '0;
    p_last_out = '0;
    p_status = '0;
    p_first = '0;
    p_dur = '0;
    p_meta_left = '0;
    p_tempo_acc = '0;
    p_tempo = '0;
    off_count = 0;
    p_ovf = 1'b0;
  endtask

  task automatic add_result(kind_t k, logic [31:0] dl, logic [7:0] st, logic [7:0] d1,
                            logic [7:0] d2, logic [7:0] pay, logic gen,
                            logic [31:0] tmp, logic [15:0] td);
    midi_res_t r;
    r.kind = k; r.delta = dl; r.status = st; r.data_one = d1; r.data_two = d2;
    r.payload = pay; r.gen_off = gen; r.tempo = tmp; r.tdiv = td;
    r.ovf = p_ovf; r.last = 1'b0;
    midi_expected.push_back(r);
    step_results++;
  endtask

  // delta is clamped at zero for out-of-order times and saturated to 32 bits
  task automatic add_event(logic [63:0] t, logic [7:0] st, logic [7:0] d1,
                           logic [7:0] d2, logic gen);
    logic [63:0] dl;
    dl = (t > p_last_out) ? t - p_last_out : 64'd0;
    if (dl > 64'hFFFF_FFFF) dl = 64'hFFFF_FFFF;
    if (t > p_last_out) p_last_out = t;
    add_result(KIND_EVENT, dl[31:0], st, d1, d2, 8'h00, gen, 32'd0, 16'd0);
  endtask

  task automatic pop_note_off();
    logic [63:0] t;
    logic [15:0] n;
    t = off_due[0];
    n = off_note[0];
    off_count--;
    for (int i = 0; i < off_count; i++) begin
      off_due[i] = off_due[i+1];
      off_note[i] = off_note[i+1];
    end
    add_event(t, n[15:8], n[7:0], 8'h00, 1'b1);
  endtask

  // equal due times keep filing order
  task automatic file_note_off(logic [63:0] t, logic [7:0] st, logic [7:0] note);
    int pos;
    pos = 0;
    p_seq++;
    if (off_count >= STORE_DEPTH) begin
      p_ovf = 1'b1;
    end else begin
      while (pos < off_count && off_due[pos] <= t) pos++;
      for (int i = off_count; i > pos; i--) begin
        off_due[i] = off_due[i-1];
        off_note[i] = off_note[i-1];
      end
      off_due[pos] = t;
      off_note[pos] = {st, note};
      off_count++;
    end
  endtask

  task automatic event_at_now(logic [7:0] st, logic [7:0] d1, logic [7:0] d2);
    while (off_count > 0 && off_due[0] <= p_now) pop_note_off();
    add_event(p_now, st, d1, d2, 1'b0);
    p_seq++;
  endtask

  task automatic convert_byte(logic [7:0] b, logic eoc);
    logic [63:0] td;
    step_results = 0;
    case (p_phase)
      PH_HEADER: begin
        if (p_skip == HDR_LAST) begin
          p_skip = '0;
          p_phase = PH_IDLE;
        end else begin
          p_skip++;
        end
      end
      PH_CH_D1: begin
        p_first = b;
        p_phase = PH_CH_D2;
      end
      PH_CH_D2: begin
        event_at_now(p_status, p_first, b);
        if (p_status[7:4] == HI_NOTE_ON) begin
          p_dur = '0;
          p_phase = PH_NOTE_DUR;
        end else begin
          p_phase = PH_IDLE;
        end
      end
      PH_ONE_D1: begin
        event_at_now(p_status, b, 8'h00);
        p_phase = PH_IDLE;
      end
      PH_NOTE_DUR: begin
        if (p_dur > (TICK_MAX >> 7)) p_dur = TICK_MAX;
        else p_dur = (p_dur << 7) | {57'd0, b[6:0]};
        if (!b[7]) begin
          file_note_off(tick_add(p_now, p_dur), p_status, p_first);
          p_phase = PH_IDLE;
        end
      end
      PH_META_TYPE: begin
        p_first = b;
        p_phase = PH_META_LEN;
      end
      PH_META_LEN: begin
        p_meta_left = b;
        p_tempo_acc = '0;
        event_at_now(STATUS_META, p_first, b);
        p_phase = (b != 0) ? PH_META_DATA : PH_IDLE;
      end
      PH_META_DATA: begin
        add_result(KIND_META, 32'd0, STATUS_META, p_first, 8'h00, b, 1'b0, 32'd0, 16'd0);
        if (p_first == META_TEMPO) p_tempo_acc = {p_tempo_acc[23:0], b};
        p_meta_left--;
        if (p_meta_left == 0) begin
          if (p_first == META_TEMPO && p_tempo == 0) p_tempo = p_tempo_acc;
          p_phase = PH_IDLE;
        end
      end
      default: begin
        if (b < STATUS_MIN) begin
          p_now = tick_add(p_now, {56'd0, b});
        end else begin
          p_status = b;
          if (b[7:4] == HI_PROG || b[7:4] == HI_CHAN_PR) p_phase = PH_ONE_D1;
          else if (b[7:4] != HI_SYSTEM) p_phase = PH_CH_D1;
          else if (b == STATUS_META) p_phase = PH_META_TYPE;
          else event_at_now(b, 8'h00, 8'h00);  // stray system status
        end
      end
    endcase
    if (eoc) begin
      td = ({32'd0, p_tempo} * 64'd3) / 64'd25000;
      while (off_count > 0) pop_note_off();
      add_result(KIND_SUMM, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, p_tempo, td[15:0]);
      clear_converter();
    end
    if (step_results > 0) midi_expected[midi_expected.size()-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  task automatic put_byte(logic [7:0] b);
    chunk_byte_t c;
    c.b = b;
    c.eoc = 1'b0;
    chunk_bytes.push_back(c);
  endtask

  task automatic end_chunk();
    chunk_bytes[chunk_bytes.size()-1].eoc = 1'b1;
    chunks_made++;
  endtask

  // data byte, now and then with the top bit set
  function automatic logic [7:0] any_data();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                       : 8'($urandom_range(0, 127));
  endfunction

  task automatic put_duration();
    int n;
    n = $urandom_range(0, 9);
    if (n == 0) begin
      repeat (4) put_byte(8'hFF);  // saturates the due time
      put_byte(8'h7F);
    end else if (n < 3) begin
      put_byte(8'($urandom_range(128, 255)));
      put_byte(8'($urandom_range(0, 127)));
    end else begin
      put_byte(8'($urandom_range(0, 127)));
    end
  endtask

  task automatic put_random_event();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 6) begin
      put_byte(8'($urandom_range(0, 127)));
    end else if (sel < 11) begin
      put_byte(8'h90 | 8'($urandom_range(0, 15)));
      put_byte(any_data());
      put_byte(any_data());
      put_duration();
    end else if (sel < 14) begin
      case ($urandom_range(0, 3))
        0: put_byte(8'h80 | 8'($urandom_range(0, 15)));
        1: put_byte(8'hA0 | 8'($urandom_range(0, 15)));
        2: put_byte(8'hB0 | 8'($urandom_range(0, 15)));
        default: put_byte(8'hE0 | 8'($urandom_range(0, 15)));
      endcase
      put_byte(any_data());
      put_byte(any_data());
    end else if (sel < 16) begin
      put_byte(8'($urandom_range(12, 13)) << 4 | 8'($urandom_range(0, 15)));
      put_byte(any_data());
    end else if (sel < 17) begin
      put_byte(8'($urandom_range(240, 254)));
    end else begin
      int len;
      len = $urandom_range(0, 4);
      put_byte(STATUS_META);
      put_byte(($urandom_range(0, 1) == 0) ? META_TEMPO : any_data());
      put_byte(8'(len));
      repeat (len) put_byte(8'($urandom));
    end
  endtask

  task automatic build_stimulus();
    int kind_sel;
    int n;
    // directed chunk: header, time bytes, note on, note off, program,
    // channel pressure, system status, tempo, empty meta, saturated duration
    put_byte(8'h00); put_byte(8'hFF); put_byte(8'h55); put_byte(8'hAA);
    put_byte(8'h00); put_byte(8'h7F);
    put_byte(8'h90); put_byte(8'h3C); put_byte(8'h7F); put_byte(8'h81); put_byte(8'h00);
    put_byte(8'h8F); put_byte(8'hFF); put_byte(8'h80);
    put_byte(8'hC5); put_byte(8'h10);
    put_byte(8'hD2); put_byte(8'hFF);
    put_byte(8'hF3);
    put_byte(8'hFF); put_byte(8'h51); put_byte(8'h03);
    put_byte(8'h07); put_byte(8'hA1); put_byte(8'h20);
    put_byte(8'hFF); put_byte(8'h01); put_byte(8'h00);
    put_byte(8'h91); put_byte(8'h40); put_byte(8'h00);
    repeat (4) put_byte(8'hFF);
    put_byte(8'h7F);
    put_byte(8'h7F);
    end_chunk();
    // chunk that ends inside its header
    put_byte(8'h12); put_byte(8'h34);
    end_chunk();
    hold_at = chunk_bytes.size();
    // store overflow: 34 notes held far past the chunk
    repeat (4) put_byte(8'($urandom));
    for (int i = 0; i < 34; i++) begin
      put_byte(8'h90 | 8'(i % 16));
      put_byte(8'(i));
      put_byte(8'h40);
      put_byte(8'h7F);
    end
    put_byte(8'h05);
    end_chunk();
    // random chunks: mostly well-formed, some cut short, some noise
    while (chunk_bytes.size() < TARGET_BYTES) begin
      kind_sel = $urandom_range(0, 9);
      repeat (4) put_byte(8'($urandom));
      if (kind_sel == 0) begin
        n = $urandom_range(1, 12);
        repeat (n) put_byte(8'($urandom));
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) put_random_event();
        if (kind_sel == 1) void'(chunk_bytes.pop_back());  // truncated event
      end
      end_chunk();
    end
    quiet_from = (chunk_bytes.size() * 85) / 100;
  endtask

  // ---------------------------------------------------------------------
  // Clock, reset, cycle limit
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, midi_expected.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driver: one byte per transaction, random idle bursts
  // ---------------------------------------------------------------------
  int in_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
      in_gap = 0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) begin
        convert_byte(in_tdata, in_tlast);
        bytes_sent++;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (bytes_sent < chunk_bytes.size() &&
                   !(bytes_sent == hold_at && midi_expected.size() != 0)) begin
        in_tvalid <= 1'b1;
        in_tdata <= chunk_bytes[bytes_sent].b;
        in_tlast <= chunk_bytes[bytes_sent].eoc;
        if (bytes_sent < quiet_from && $urandom_range(0, 5) == 0)
          in_gap = $urandom_range(1, 15);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each result transaction with the oldest expectation
  // ---------------------------------------------------------------------
  int out_gap;

  always @(posedge clk) begin
    midi_res_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (midi_expected.size() == 0) begin
          $display("%0t unexpected result: kind %0d data %h", $time, out_tuser, out_tdata);
          errors++;
        end else begin
          e = midi_expected.pop_front();
          if (out_tuser !== e.kind || out_tdata[31:0] !== e.delta ||
              out_tdata[39:32] !== e.status || out_tdata[47:40] !== e.data_one ||
              out_tdata[55:48] !== e.data_two || out_tdata[63:56] !== e.payload ||
              out_tdata[64] !== e.gen_off || out_tdata[96:65] !== e.tempo ||
              out_tdata[112:97] !== e.tdiv || out_tdata[113] !== e.ovf ||
              out_tlast !== e.last) begin
            $display("%0t mismatch result %0d", $time, results_seen);
            $display("  expected kind %0d delta %h st %h d1 %h d2 %h pay %h gen %b",
                     e.kind, e.delta, e.status, e.data_one, e.data_two, e.payload,
                     e.gen_off);
            $display("           tempo %h tdiv %h ovf %b last %b",
                     e.tempo, e.tdiv, e.ovf, e.last);
            $display("  actual   kind %0d delta %h st %h d1 %h d2 %h pay %h gen %b",
                     out_tuser, out_tdata[31:0], out_tdata[39:32], out_tdata[47:40],
                     out_tdata[55:48], out_tdata[63:56], out_tdata[64]);
            $display("           tempo %h tdiv %h ovf %b last %b",
                     out_tdata[96:65], out_tdata[112:97], out_tdata[113], out_tlast);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (bytes_sent < quiet_from && $urandom_range(0, 5) == 0)
          out_gap = $urandom_range(1, 15);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    bytes_sent = 0;
    results_seen = 0;
    errors = 0;
    cycles = 0;
    chunks_made = 0;
    clear_converter();
    build_stimulus();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (bytes_sent == chunk_bytes.size());
    wait (midi_expected.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d bytes in %0d chunks, %0d results checked", bytes_sent,
             chunks_made, results_seen);
    $display("incl. store overflow, saturated durations, tempo, truncated chunks");
    if (errors == 0 && midi_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors, %0d results missing", errors, midi_expected.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> xmidi_to_midi_event_converter.f
+incdir+rtl
rtl/xmtm_pkg.sv
rtl/xmtm_store.sv
rtl/xmtm_div.sv
rtl/xmidi_to_midi_event_converter.sv
rtl/xmtm_checker.sv
dv/tb.sv
